// ===== sv/bsd_pkg.sv =====
// bsd_pkg: shared types, codes and tables of the bank switch and port decoder
// no dependencies; imported by the interfaces and by every module
`default_nettype none

package bsd_pkg;

    localparam int OP_W     = 2;
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int TGT_W    = 2;
    localparam int BANK_W   = 3;
    localparam int OFFSET_W = 14;
    localparam int STROBE_W = 8;
    localparam int SRC_W    = 3;
    localparam int PORT_W   = 2;
    localparam int MODE_W   = 2;
    localparam int MODEL_W  = 2;
    localparam int LAYOUT_W = 3;
    localparam int REGION_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_MEM_RD = 2'd0,
        OP_MEM_WR = 2'd1,
        OP_IO_WR  = 2'd2,
        OP_IO_RD  = 2'd3
    } op_t;

    typedef enum logic [TGT_W-1:0] {
        TGT_RAM  = 2'd0,
        TGT_LROM = 2'd1,
        TGT_UROM = 2'd2,
        TGT_IO   = 2'd3
    } target_t;

    typedef enum logic [SRC_W-1:0] {
        SRC_CRTC_STATUS = 3'd0,
        SRC_CRTC_REG    = 3'd1,
        SRC_PPI         = 3'd2,
        SRC_CONST_FF    = 3'd3,
        SRC_CONST_00    = 3'd4,
        SRC_NONE        = 3'd5
    } source_t;

    typedef enum logic [MODEL_W-1:0] {
        MODEL_SMALL   = 2'd0,
        MODEL_LARGE   = 2'd1,
        MODEL_COMPACT = 2'd2,
        MODEL_UNNAMED = 2'd3
    } model_t;

    // data bits 7..6 of a gate array write
    typedef enum logic [1:0] {
        GA_PEN    = 2'd0,
        GA_COLOUR = 2'd1,
        GA_MODE   = 2'd2,
        GA_RAMCFG = 2'd3
    } ga_func_t;

    // port bits 9..8 of a crtc access
    typedef enum logic [PORT_W-1:0] {
        CRTC_SELECT = 2'd0,
        CRTC_WRITE  = 2'd1,
        CRTC_STATUS = 2'd2,
        CRTC_READ   = 2'd3
    } crtc_func_t;

    localparam int STB_PEN    = 0;
    localparam int STB_COLOUR = 1;
    localparam int STB_MODE   = 2;
    localparam int STB_IRQ    = 3;
    localparam int STB_RAMCFG = 4;
    localparam int STB_CRTC_S = 5;
    localparam int STB_CRTC_W = 6;
    localparam int STB_PPI    = 7;

    localparam int REGION_LOW  = 0;
    localparam int REGION_HIGH = 3;

    localparam logic [BANK_W-1:0] BANK_TABLE [8][4] = '{
        '{3'd0, 3'd1, 3'd2, 3'd3},
        '{3'd0, 3'd1, 3'd2, 3'd7},
        '{3'd4, 3'd5, 3'd6, 3'd7},
        '{3'd0, 3'd3, 3'd2, 3'd7},
        '{3'd0, 3'd4, 3'd2, 3'd3},
        '{3'd0, 3'd5, 3'd2, 3'd3},
        '{3'd0, 3'd6, 3'd2, 3'd3},
        '{3'd0, 3'd7, 3'd2, 3'd3}
    };

    typedef struct packed {
        logic [MODE_W-1:0]   video_mode;
        logic                lower_rom_off;
        logic                upper_rom_off;
        logic [LAYOUT_W-1:0] bank_layout;
    } bsd_state_t;

    typedef struct packed {
        logic [STROBE_W-1:0] write_strobes;
        source_t             read_source;
        logic [PORT_W-1:0]   chip_port;
    } bsd_io_res_t;

    typedef struct packed {
        target_t             target;
        logic [BANK_W-1:0]   ram_bank;
        logic [OFFSET_W-1:0] bank_offset;
    } bsd_mem_res_t;

endpackage

`default_nettype wire

// ===== sv/bsd_req_if.sv =====
// bsd_req_if: valid/ready channel carrying one bus transaction into the decoder
// depends on bsd_pkg for field widths
`default_nettype none

interface bsd_req_if
    import bsd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_value;

    modport source (output valid, output operation, output address, output write_value,
                    input ready);
    modport sink   (input valid, input operation, input address, input write_value,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/bsd_rsp_if.sv =====
// bsd_rsp_if: valid/ready channel carrying one decode result out of the block
// depends on bsd_pkg for field widths
`default_nettype none

interface bsd_rsp_if
    import bsd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [TGT_W-1:0]    target;
    logic [BANK_W-1:0]   ram_bank;
    logic [OFFSET_W-1:0] bank_offset;
    logic [STROBE_W-1:0] write_strobes;
    logic [SRC_W-1:0]    read_source;
    logic [PORT_W-1:0]   chip_port;
    logic [MODE_W-1:0]   screen_mode;

    modport source (output valid, output target, output ram_bank, output bank_offset,
                    output write_strobes, output read_source, output chip_port,
                    output screen_mode, input ready);
    modport sink   (input valid, input target, input ram_bank, input bank_offset,
                    input write_strobes, input read_source, input chip_port,
                    input screen_mode, output ready);
endinterface

`default_nettype wire

// ===== sv/bsd_io_decode.sv =====
// bsd_io_decode: i/o write strobes, i/o read source and gate array state update
// depends on bsd_pkg
`default_nettype none

module bsd_io_decode
    import bsd_pkg::*;
(
    input  wire op_t               operation,
    input  wire logic [ADDR_W-1:0] address,
    input  wire logic [DATA_W-1:0] write_value,
    input  wire logic              large_model,
    input  wire bsd_state_t        state_cur,
    output bsd_io_res_t            io_res,
    output bsd_state_t             state_next
);

    logic              is_wr;
    logic              is_rd;
    logic              ga_sel;
    logic              crtc_sel;
    ga_func_t          ga_func;
    logic [PORT_W-1:0] func;
    logic              mode_wr;

    always_comb
    begin
        is_wr    = (operation == OP_IO_WR);
        is_rd    = (operation == OP_IO_RD);
        ga_sel   = !address[15] && address[14];
        crtc_sel = !address[14];
        ga_func  = ga_func_t'(write_value[7:6]);
        func     = address[9:8];
        mode_wr  = is_wr && ga_sel && (ga_func == GA_MODE);

        io_res.write_strobes             = '0;
        io_res.write_strobes[STB_PEN]    = is_wr && ga_sel && (ga_func == GA_PEN);
        io_res.write_strobes[STB_COLOUR] = is_wr && ga_sel && (ga_func == GA_COLOUR);
        io_res.write_strobes[STB_MODE]   = mode_wr;
        io_res.write_strobes[STB_IRQ]    = mode_wr && write_value[4];
        io_res.write_strobes[STB_RAMCFG] = is_wr && !address[15] && (ga_func == GA_RAMCFG)
                                           && large_model;
        io_res.write_strobes[STB_CRTC_S] = is_wr && crtc_sel && (func == CRTC_SELECT);
        io_res.write_strobes[STB_CRTC_W] = is_wr && crtc_sel && (func == CRTC_WRITE);
        io_res.write_strobes[STB_PPI]    = is_wr && !crtc_sel && !address[11];

        io_res.read_source = SRC_NONE;
        if (is_rd)
        begin
            if (crtc_sel)
            begin
                unique case (crtc_func_t'(func))
                    CRTC_STATUS: io_res.read_source = SRC_CRTC_STATUS;
                    CRTC_READ:   io_res.read_source = SRC_CRTC_REG;
                    default:     io_res.read_source = SRC_CONST_FF;
                endcase
            end
            else if (!address[11])
            begin
                io_res.read_source = SRC_PPI;
            end
            else
            begin
                io_res.read_source = SRC_CONST_00;
            end
        end

        io_res.chip_port = (is_wr || is_rd) ? func : '0;

        state_next = state_cur;
        if (mode_wr)
        begin
            state_next.video_mode    = write_value[1:0];
            state_next.lower_rom_off = write_value[2];
            state_next.upper_rom_off = write_value[3];
        end
        if (io_res.write_strobes[STB_RAMCFG])
        begin
            state_next.bank_layout = write_value[LAYOUT_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== sv/bsd_mem_map.sv =====
// bsd_mem_map: maps a memory transaction to ram bank or rom through the bank table
// depends on bsd_pkg
`default_nettype none

module bsd_mem_map
    import bsd_pkg::*;
(
    input  wire op_t               operation,
    input  wire logic [ADDR_W-1:0] address,
    input  wire logic              large_model,
    input  wire bsd_state_t        state_cur,
    output bsd_mem_res_t           mem_res
);

    logic [REGION_W-1:0] region;
    logic [LAYOUT_W-1:0] layout;

    always_comb
    begin
        region = address[ADDR_W-1:OFFSET_W];
        layout = large_model ? state_cur.bank_layout : '0;

        mem_res.target      = TGT_IO;
        mem_res.ram_bank    = '0;
        mem_res.bank_offset = '0;

        unique case (operation) inside
            OP_MEM_RD, OP_MEM_WR:
            begin
                mem_res.target      = TGT_RAM;
                mem_res.ram_bank    = BANK_TABLE[layout][region];
                mem_res.bank_offset = address[OFFSET_W-1:0];
                if (operation == OP_MEM_RD)
                begin
                    if ((region == REGION_W'(REGION_LOW)) && !state_cur.lower_rom_off)
                    begin
                        mem_res.target   = TGT_LROM;
                        mem_res.ram_bank = '0;
                    end
                    else if ((region == REGION_W'(REGION_HIGH)) && !state_cur.upper_rom_off)
                    begin
                        mem_res.target   = TGT_UROM;
                        mem_res.ram_bank = '0;
                    end
                end
            end
            default:
            begin
                mem_res.target = TGT_IO;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/bank_switch_and_port_decoder.sv =====
// bank_switch_and_port_decoder: input register, decode logic, result register
// an accepted transaction is held in the input register, decoded, and loaded into the result register
// throughput: one transaction per cycle unless rsp.ready stalls the two-register pipeline
// reset: rst_n clears valids, machine model, video mode, rom disables and bank layout
// depends on bsd_pkg, bsd_req_if, bsd_rsp_if, bsd_io_decode, bsd_mem_map
`default_nettype none

module bank_switch_and_port_decoder
    import bsd_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic [MODEL_W-1:0] cfg_data,
    bsd_req_if.sink             req,
    bsd_rsp_if.source           rsp
);

    logic              in_valid_reg;
    op_t               in_op_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    logic [DATA_W-1:0] in_data_reg;

    model_t            model_reg;
    bsd_state_t        state_reg;
    bsd_state_t        state_next;

    logic              out_valid_reg;
    bsd_io_res_t       io_res;
    bsd_mem_res_t      mem_res;
    bsd_io_res_t       io_res_reg;
    bsd_mem_res_t      mem_res_reg;
    logic [MODE_W-1:0] mode_out_reg;

    logic              large_model;
    logic              out_adv;
    logic              in_adv;

    assign large_model = (model_reg == MODEL_LARGE);
    assign out_adv     = !out_valid_reg || rsp.ready;
    assign in_adv      = !in_valid_reg || out_adv;
    assign req.ready   = in_adv;

    bsd_io_decode u_io_decode (
        .operation   (in_op_reg),
        .address     (in_addr_reg),
        .write_value (in_data_reg),
        .large_model (large_model),
        .state_cur   (state_reg),
        .io_res      (io_res),
        .state_next  (state_next)
    );

    bsd_mem_map u_mem_map (
        .operation   (in_op_reg),
        .address     (in_addr_reg),
        .large_model (large_model),
        .state_cur   (state_reg),
        .mem_res     (mem_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_reg <= MODEL_SMALL;
        end
        else if (cfg_we)
        begin
            model_reg <= model_t'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_adv)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_adv && req.valid)
        begin
            in_op_reg   <= op_t'(req.operation);
            in_addr_reg <= req.address;
            in_data_reg <= req.write_value;
        end
    end

    // state moves with the transaction leaving the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && in_valid_reg)
        begin
            io_res_reg   <= io_res;
            mem_res_reg  <= mem_res;
            mode_out_reg <= state_next.video_mode;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.target        = mem_res_reg.target;
    assign rsp.ram_bank      = mem_res_reg.ram_bank;
    assign rsp.bank_offset   = mem_res_reg.bank_offset;
    assign rsp.write_strobes = io_res_reg.write_strobes;
    assign rsp.read_source   = io_res_reg.read_source;
    assign rsp.chip_port     = io_res_reg.chip_port;
    assign rsp.screen_mode   = mode_out_reg;

    a_rom_no_bank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (mem_res_reg.target == TGT_LROM || mem_res_reg.target == TGT_UROM)
        |-> mem_res_reg.ram_bank == '0)
        else $error("rom result carries a ram bank");

    a_strobe_io_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (io_res_reg.write_strobes != '0)
        |-> mem_res_reg.target == TGT_IO)
        else $error("write strobes on a memory transaction");

    a_source_io_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (io_res_reg.read_source != SRC_NONE)
        |-> mem_res_reg.target == TGT_IO && io_res_reg.write_strobes == '0)
        else $error("read source on a non io-read transaction");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !rsp.ready |-> !req.ready)
        else $error("input taken while pipeline is full");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid_reg && out_adv) |=> $stable(state_reg))
        else $error("state changed without a transaction");

endmodule

`default_nettype wire
